// ===== rtl/core/sbb_pkg.sv =====
// Shared types and constants of the shiftable byte buffer with sync hunter.
// Command codes, register indexes, request and result payloads, hunter control.
// No dependencies.
`timescale 1ns / 1ps

package sbb_pkg;

  // Fixed field widths of the request and result payloads
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CNT_W      = 9;
  localparam int unsigned SYNC_LEN_W = 3;
  localparam int unsigned PAT_W      = 32;
  localparam int unsigned PAT_BYTES  = 4;
  // Holds a pattern length up to 15 bytes
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [SYNC_LEN_W-1:0] SYNC_LEN_RST = 3'd2;
  localparam logic [PAT_W-1:0]      SYNC_PAT_RST = 32'h0000_6505;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND  = 3'd0,
    CMD_CONSUME = 3'd1,
    CMD_SHIFT   = 3'd2,
    CMD_SYNC    = 3'd3,
    CMD_PEEK    = 3'd4
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_LEN     = 1'b0,
    CFG_SYNC_PATTERN = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] data_byte;
    logic [CNT_W-1:0]  count;
  } req_t;

  typedef struct packed {
    logic              status;
    logic              found;
    logic [CNT_W-1:0]  discarded;
    logic [BYTE_W-1:0] peek_data;
    logic [CNT_W-1:0]  readable;
    logic [CNT_W-1:0]  writable;
  } rsp_t;

  // Controller to hunter
  typedef struct packed {
    logic              clear;
    logic              push;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  len;
  } hunt_cmd_t;

  // Hunter to controller
  typedef struct packed {
    logic             full_hit;
    logic [LEN_W-1:0] tail_len;
  } hunt_res_t;

endpackage

// ===== rtl/core/sbb_stream_if.sv =====
// Valid/ready channel carrying one payload of type T per request.
// Used for the request and result channels of the buffer; no dependencies.
`timescale 1ns / 1ps

interface sbb_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/sbb_store.sv =====
// Byte store: one write port and one read port, read data registered.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module sbb_store #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/sbb_hunter.sv =====
// Sync pattern hunter: sliding window over the streamed bytes, full-length
// match on each new byte and tail (cut pattern) search at end of data.
// Depends on sbb_pkg.
`timescale 1ns / 1ps

module sbb_hunter import sbb_pkg::*; #(
  parameter int unsigned PATTERN_MAX = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hunt_cmd_t        hunt_i,
  input  logic [PAT_W-1:0] pattern_i,
  output hunt_res_t        hunt_o
);

  localparam int unsigned IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  logic [BYTE_W-1:0] hist_q [PATTERN_MAX];
  logic [BYTE_W-1:0] hist_d [PATTERN_MAX];
  logic [BYTE_W-1:0] pat_b  [PATTERN_MAX];
  logic [LEN_W-1:0]  seen_q, seen_d;
  logic [LEN_W-1:0]  idx_full;
  logic [IW-1:0]     idx;
  logic              hit;
  logic              tail_ok;

  // Pattern bytes; those beyond the register count as zero
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      pat_b[i] = '0;
      if (i < PAT_BYTES) begin
        pat_b[i] = pattern_i[8*(i % PAT_BYTES) +: 8];
      end
    end
  end

  // Window after this push: entry 0 is the newest byte
  always_comb begin
    hist_d[0] = hunt_i.data;
    for (int i = 1; i < PATTERN_MAX; i++) begin
      hist_d[i] = hist_q[i-1];
    end
    seen_d = (seen_q == LEN_W'(PATTERN_MAX)) ? seen_q : seen_q + LEN_W'(1);
  end

  // Full-length match ending at the pushed byte
  always_comb begin
    hit      = (seen_d >= hunt_i.len);
    idx_full = '0;
    idx      = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (LEN_W'(i) < hunt_i.len) begin
        idx_full = hunt_i.len - LEN_W'(i) - LEN_W'(1);
        idx      = idx_full[IW-1:0];
        if (hist_d[idx] != pat_b[i]) begin
          hit = 1'b0;
        end
      end
    end
    hunt_o.full_hit = hunt_i.push && hit;
  end

  // Longest cut pattern that matches the last bytes of the data
  always_comb begin
    hunt_o.tail_len = '0;
    tail_ok         = 1'b0;
    for (int n = 1; n < PATTERN_MAX; n++) begin
      tail_ok = (LEN_W'(n) < hunt_i.len) && (LEN_W'(n) <= seen_q);
      for (int i = 0; i < n; i++) begin
        if (hist_q[n-1-i] != pat_b[i]) begin
          tail_ok = 1'b0;
        end
      end
      if (tail_ok) begin
        hunt_o.tail_len = LEN_W'(n);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else if (hunt_i.clear) begin
      seen_q <= '0;
    end else if (hunt_i.push) begin
      seen_q <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hunt_i.push) begin
      hist_q <= hist_d;
    end
  end

endmodule

// ===== rtl/core/sbb_ctrl.sv =====
// Command sequencer: read/write positions, store access for shift and sync
// walks, result register. Depends on sbb_pkg; drives sbb_store and sbb_hunter.
`timescale 1ns / 1ps

module sbb_ctrl import sbb_pkg::*; #(
  parameter int unsigned DEPTH       = 256,
  parameter int unsigned PATTERN_MAX = 4,
  parameter int unsigned AW          = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  req_t                  req_i,
  output logic                  rsp_valid_o,
  input  logic                  rsp_ready_i,
  output rsp_t                  rsp_o,
  input  logic [SYNC_LEN_W-1:0] sync_len_i,
  output logic                  mem_we_o,
  output logic [AW-1:0]         mem_waddr_o,
  output logic [BYTE_W-1:0]     mem_wdata_o,
  output logic                  mem_re_o,
  output logic [AW-1:0]         mem_raddr_o,
  input  logic [BYTE_W-1:0]     mem_rdata_i,
  output hunt_cmd_t             hunt_o,
  input  hunt_res_t             hunt_i
);

  localparam int unsigned PW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (PW > CNT_W) ? PW : CNT_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SHIFT = 5'b00010,
    S_SYNC  = 5'b00100,
    S_TAIL  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [PW-1:0]    rp_q, rp_d, wp_q, wp_d;
  logic [PW-1:0]    rd_cnt_q, rd_cnt_d, wr_cnt_q, wr_cnt_d;
  logic             rvalid_q, rvalid_d;
  logic             status_q, status_d, found_q, found_d, peek_ok_q, peek_ok_d;
  logic [PW-1:0]    disc_q, disc_d;
  logic             rsp_valid_q, rsp_valid_d;
  rsp_t             rsp_q, rsp_d;

  logic [PW-1:0]    readable;
  logic [PW-1:0]    rd_addr, peek_addr, off_hit, off_tail;
  logic             rd_more;
  logic [LEN_W-1:0] len_eff;

  assign readable  = wp_q - rp_q;
  assign rd_addr   = rp_q + rd_cnt_q;
  assign peek_addr = rp_q + PW'(req_i.count);
  assign rd_more   = (rd_cnt_q != readable);
  assign len_eff   = (LEN_W'(sync_len_i) > LEN_W'(PATTERN_MAX)) ?
                     LEN_W'(PATTERN_MAX) : LEN_W'(sync_len_i);
  // Byte index of the hit minus pattern length plus one gives the match start
  assign off_hit   = wr_cnt_q + PW'(1) - PW'(len_eff);
  assign off_tail  = readable - PW'(hunt_i.tail_len);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    rp_d        = rp_q;
    wp_d        = wp_q;
    rd_cnt_d    = rd_cnt_q;
    wr_cnt_d    = wr_cnt_q;
    rvalid_d    = 1'b0;
    status_d    = status_q;
    found_d     = found_q;
    peek_ok_d   = peek_ok_q;
    disc_d      = disc_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    rsp_d       = rsp_q;
    req_ready_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    hunt_o.clear = 1'b0;
    hunt_o.push  = 1'b0;
    hunt_o.data  = mem_rdata_i;
    hunt_o.len   = len_eff;

    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          status_d  = 1'b0;
          found_d   = 1'b0;
          disc_d    = '0;
          peek_ok_d = 1'b0;
          state_d   = S_DONE;
          case (req_i.cmd)
            CMD_APPEND: begin
              if (wp_q == PW'(DEPTH)) begin
                status_d = 1'b1;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = wp_q[AW-1:0];
                mem_wdata_o = req_i.data_byte;
                wp_d        = wp_q + PW'(1);
              end
            end
            CMD_CONSUME: begin
              if (CW'(req_i.count) > CW'(readable)) begin
                status_d = 1'b1;
              end else begin
                rp_d = PW'(CW'(rp_q) + CW'(req_i.count));
              end
            end
            CMD_SHIFT: begin
              if ((rp_q != '0) && (readable != '0)) begin
                rd_cnt_d = '0;
                wr_cnt_d = '0;
                state_d  = S_SHIFT;
              end else begin
                wp_d = readable;
                rp_d = '0;
              end
            end
            CMD_SYNC: begin
              if (sync_len_i == '0) begin
                status_d = 1'b1;
              end else begin
                hunt_o.clear = 1'b1;
                rd_cnt_d     = '0;
                wr_cnt_d     = '0;
                state_d      = (readable == '0) ? S_TAIL : S_SYNC;
              end
            end
            CMD_PEEK: begin
              if (CW'(req_i.count) >= CW'(readable)) begin
                status_d = 1'b1;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = peek_addr[AW-1:0];
                peek_ok_d   = 1'b1;
              end
            end
            default: begin
              status_d = 1'b1;
            end
          endcase
        end
      end

      // Copy unread bytes to the front: read ahead, write each byte in the cycle after its read
      S_SHIFT: begin
        mem_re_o    = rd_more;
        mem_raddr_o = rd_addr[AW-1:0];
        rvalid_d    = rd_more;
        if (rd_more) begin
          rd_cnt_d = rd_cnt_q + PW'(1);
        end
        if (rvalid_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = wr_cnt_q[AW-1:0];
          mem_wdata_o = mem_rdata_i;
          wr_cnt_d    = wr_cnt_q + PW'(1);
          if (wr_cnt_q == readable - PW'(1)) begin
            wp_d    = readable;
            rp_d    = '0;
            state_d = S_DONE;
          end
        end
      end

      // Stream unread bytes through the hunter; stop at the first full match
      S_SYNC: begin
        hunt_o.push = rvalid_q;
        mem_re_o    = rd_more && !hunt_i.full_hit;
        mem_raddr_o = rd_addr[AW-1:0];
        rvalid_d    = mem_re_o;
        if (mem_re_o) begin
          rd_cnt_d = rd_cnt_q + PW'(1);
        end
        if (rvalid_q) begin
          wr_cnt_d = wr_cnt_q + PW'(1);
          if (hunt_i.full_hit) begin
            rp_d    = rp_q + off_hit;
            disc_d  = off_hit;
            found_d = 1'b1;
            state_d = S_DONE;
          end else if (wr_cnt_q == readable - PW'(1)) begin
            state_d = S_TAIL;
          end
        end
      end

      // No full match: keep the longest cut-pattern match at the end
      S_TAIL: begin
        rp_d    = rp_q + off_tail;
        disc_d  = off_tail;
        found_d = 1'b0;
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          rsp_valid_d     = 1'b1;
          rsp_d.status    = status_q;
          rsp_d.found     = found_q;
          rsp_d.discarded = CNT_W'(disc_q);
          rsp_d.peek_data = peek_ok_q ? mem_rdata_i : '0;
          rsp_d.readable  = CNT_W'(readable);
          rsp_d.writable  = CNT_W'(PW'(DEPTH) - wp_q);
          state_d         = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rp_q        <= '0;
      wp_q        <= '0;
      rd_cnt_q    <= '0;
      wr_cnt_q    <= '0;
      rvalid_q    <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rp_q        <= rp_d;
      wp_q        <= wp_d;
      rd_cnt_q    <= rd_cnt_d;
      wr_cnt_q    <= wr_cnt_d;
      rvalid_q    <= rvalid_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    found_q   <= found_d;
    peek_ok_q <= peek_ok_d;
    disc_q    <= disc_d;
    rsp_q     <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // Checks
  a_rp_le_wp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rp_q <= wp_q)
    else $error("read position passed write position");

  a_wp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= PW'(DEPTH))
    else $error("write position beyond store");

  a_rvalid_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvalid_q |-> (state_q == S_SHIFT || state_q == S_SYNC))
    else $error("read data pending outside a store walk");

  a_no_write_in_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> !mem_we_o)
    else $error("store written while holding a result");

  a_shift_resets_rp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT && state_d == S_DONE) |=> (rp_q == '0))
    else $error("read position not at front after shift");

endmodule

// ===== rtl/core/shiftable_byte_buffer_sync_hunter_unit.sv =====
// Linear byte buffer with append, consume, shift (compaction), peek and sync
// pattern search. Every request returns one result. A shift with unread data
// away from the front and a sync both walk the byte store one byte per cycle
// through its single read port. A new request is taken while the previous
// result still waits in the output register. The store needs no clearing
// after reset. Configuration is written through a plain write port; the user
// must write it only while the buffer is idle, the block does not enforce it.
// Depends on sbb_pkg, sbb_stream_if, sbb_store, sbb_hunter and sbb_ctrl.
`timescale 1ns / 1ps

module shiftable_byte_buffer_sync_hunter_unit import sbb_pkg::*; #(
  parameter int unsigned DEPTH       = 256,
  parameter int unsigned PATTERN_MAX = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  sbb_stream_if.sink           req_i,
  sbb_stream_if.source         rsp_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [PAT_W-1:0]     cfg_wdata_i
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [SYNC_LEN_W-1:0] sync_len_q;
  logic [PAT_W-1:0]      sync_pat_q;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [BYTE_W-1:0] mem_wdata, mem_rdata;
  hunt_cmd_t         hunt_cmd;
  hunt_res_t         hunt_res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_len_q <= SYNC_LEN_RST;
      sync_pat_q <= SYNC_PAT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SYNC_LEN:     sync_len_q <= cfg_wdata_i[SYNC_LEN_W-1:0];
        CFG_SYNC_PATTERN: sync_pat_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  sbb_ctrl #(
    .DEPTH       (DEPTH),
    .PATTERN_MAX (PATTERN_MAX),
    .AW          (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_i       (req_i.data),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_o       (rsp_o.data),
    .sync_len_i  (sync_len_q),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .hunt_o      (hunt_cmd),
    .hunt_i      (hunt_res)
  );

  sbb_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  sbb_hunter #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_hunter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .hunt_i    (hunt_cmd),
    .pattern_i (sync_pat_q),
    .hunt_o    (hunt_res)
  );

endmodule

// ===== verif/tb_shiftable_byte_buffer_sync_hunter_unit.sv =====
// Testbench of the shiftable byte buffer with sync hunter: a directed table, then
// random framed traffic with sync patterns, checked against a shadow buffer model.
// Depends on sbb_pkg, sbb_stream_if and shiftable_byte_buffer_sync_hunter_unit.
`timescale 1ns / 1ps

module tb_shiftable_byte_buffer_sync_hunter_unit;
  import sbb_pkg::*;

  localparam int unsigned DEPTH       = 256;
  localparam int unsigned PATTERN_MAX = 4;
  localparam int unsigned MAX_GAP     = 18;
  localparam int unsigned HOLD_CYCLES = 600;
  // Longest legal silence is the output hold
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES = 300;
  localparam int unsigned PRINT_CAP   = 40;

  // Command codes the block does not define
  localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

  localparam rsp_t RSP_EMPTY_OK  = '{status: 1'b0, found: 1'b0, discarded: '0,
                                     peek_data: '0, readable: '0, writable: 9'd256};
  localparam rsp_t RSP_EMPTY_REJ = '{status: 1'b1, found: 1'b0, discarded: '0,
                                     peek_data: '0, readable: '0, writable: 9'd256};
  localparam rsp_t RSP_NONE      = '0;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] data_byte;
    logic [CNT_W-1:0]  count;
    logic              given;
    rsp_t              want;
  } step_row_t;

  // Directed steps under the reset configuration (pattern 05 65, length 2)
  localparam int unsigned N_ROWS = 25;
  localparam step_row_t DIRECTED_ROWS [N_ROWS] = '{
    '{CMD_CONSUME, 8'h00, 9'd0,   1'b1, RSP_EMPTY_OK},
    '{CMD_PEEK,    8'h00, 9'd0,   1'b1, RSP_EMPTY_REJ},
    '{CMD_SYNC,    8'h00, 9'd0,   1'b1, RSP_EMPTY_OK},
    '{CMD_RSVD5,   8'h00, 9'd0,   1'b1, RSP_EMPTY_REJ},
    '{CMD_RSVD7,   8'hFF, 9'd511, 1'b1, RSP_EMPTY_REJ},
    '{CMD_SHIFT,   8'h00, 9'd0,   1'b1, RSP_EMPTY_OK},
    '{CMD_CONSUME, 8'h00, 9'd1,   1'b1, RSP_EMPTY_REJ},
    '{CMD_CONSUME, 8'hFF, 9'd511, 1'b1, RSP_EMPTY_REJ},
    '{CMD_APPEND,  8'h00, 9'd0,   1'b1, '{1'b0, 1'b0, 9'd0, 8'h00, 9'd1, 9'd255}},
    '{CMD_APPEND,  8'hFF, 9'd511, 1'b1, '{1'b0, 1'b0, 9'd0, 8'h00, 9'd2, 9'd254}},
    '{CMD_APPEND,  8'h05, 9'd0,   1'b0, RSP_NONE},
    '{CMD_APPEND,  8'h65, 9'd0,   1'b0, RSP_NONE},
    '{CMD_APPEND,  8'h05, 9'd0,   1'b0, RSP_NONE},
    '{CMD_PEEK,    8'h00, 9'd0,   1'b0, RSP_NONE},
    '{CMD_PEEK,    8'h00, 9'd4,   1'b0, RSP_NONE},
    '{CMD_PEEK,    8'h00, 9'd5,   1'b0, RSP_NONE},
    '{CMD_PEEK,    8'hFF, 9'd511, 1'b0, RSP_NONE},
    '{CMD_SYNC,    8'h00, 9'd0,   1'b0, RSP_NONE},
    '{CMD_CONSUME, 8'h00, 9'd2,   1'b0, RSP_NONE},
    '{CMD_SYNC,    8'h00, 9'd0,   1'b0, RSP_NONE},
    '{CMD_SHIFT,   8'h00, 9'd0,   1'b0, RSP_NONE},
    '{CMD_APPEND,  8'h64, 9'd0,   1'b0, RSP_NONE},
    '{CMD_SYNC,    8'h00, 9'd0,   1'b0, RSP_NONE},
    '{CMD_CONSUME, 8'h00, 9'd0,   1'b0, RSP_NONE},
    '{CMD_SHIFT,   8'h00, 9'd0,   1'b0, RSP_NONE}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [PAT_W-1:0]     cfg_wdata_i;

  sbb_stream_if #(.T(req_t)) req_if ();
  sbb_stream_if #(.T(rsp_t)) rsp_if ();

  shiftable_byte_buffer_sync_hunter_unit #(
    .DEPTH      (DEPTH),
    .PATTERN_MAX(PATTERN_MAX)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Shadow copy of the buffer and its configuration
  logic [BYTE_W-1:0]     shadow_store [DEPTH];
  int unsigned           shadow_rd;
  int unsigned           shadow_wr;
  logic [SYNC_LEN_W-1:0] shadow_len;
  logic [PAT_W-1:0]      shadow_pat;

  rsp_t        pending_rsp_q [$];
  int unsigned n_errors;
  int unsigned n_requests;
  int unsigned n_checked;
  int unsigned n_found;
  int unsigned n_rejected;
  int unsigned n_settings;
  int unsigned n_holds;
  int unsigned rsp_hold_cycles;
  bit          tx_no_idle;
  bit          rx_no_idle;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    for (int unsigned k = 0; k < DEPTH; k++) shadow_store[k] = '0;
    shadow_rd       = 0;
    shadow_wr       = 0;
    shadow_len      = SYNC_LEN_RST;
    shadow_pat      = SYNC_PAT_RST;
    n_errors        = 0;
    n_requests      = 0;
    n_checked       = 0;
    n_found         = 0;
    n_rejected      = 0;
    n_settings      = 0;
    n_holds         = 0;
    rsp_hold_cycles = 0;
    tx_no_idle      = 1'b0;
    rx_no_idle      = 1'b0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    n_errors++;
    if (n_errors <= PRINT_CAP)
      $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want, n_checked);
  endtask

  function automatic logic [BYTE_W-1:0] pattern_byte(input int unsigned idx);
    if (idx >= PAT_BYTES) return '0;
    return shadow_pat[8*idx +: 8];
  endfunction

  // Applies one request to the shadow buffer and returns the result it must give
  function automatic rsp_t predict_response(input req_t r);
    rsp_t        o;
    int unsigned avail;
    int unsigned len;
    int unsigned off;
    int unsigned n;
    int unsigned i;
    bit          hit;
    o     = '0;
    avail = shadow_wr - shadow_rd;
    case (r.cmd)
      CMD_APPEND: begin
        if (shadow_wr >= DEPTH) begin
          o.status = 1'b1;
        end else begin
          shadow_store[shadow_wr] = r.data_byte;
          shadow_wr++;
        end
      end
      CMD_CONSUME: begin
        if (r.count > avail) o.status = 1'b1;
        else shadow_rd += r.count;
      end
      CMD_SHIFT: begin
        for (i = 0; i < avail; i++) shadow_store[i] = shadow_store[shadow_rd + i];
        shadow_wr = avail;
        shadow_rd = 0;
      end
      CMD_SYNC: begin
        len = shadow_len;
        if (len == 0) begin
          o.status = 1'b1;
        end else begin
          if (len > PATTERN_MAX) len = PATTERN_MAX;
          // First offset where the pattern, cut to what is left, matches
          off = 0;
          hit = 1'b0;
          while (off < avail && !hit) begin
            n   = (avail - off > len) ? len : avail - off;
            hit = 1'b1;
            for (i = 0; i < n; i++)
              if (pattern_byte(i) != shadow_store[shadow_rd + off + i]) hit = 1'b0;
            if (!hit) off++;
          end
          o.found     = (avail - off >= len);
          o.discarded = CNT_W'(off);
          shadow_rd  += off;
          if (o.found) n_found++;
        end
      end
      CMD_PEEK: begin
        if (r.count >= avail) o.status = 1'b1;
        else o.peek_data = shadow_store[shadow_rd + r.count];
      end
      default: o.status = 1'b1;
    endcase
    o.readable = CNT_W'(shadow_wr - shadow_rd);
    o.writable = CNT_W'(DEPTH - shadow_wr);
    if (o.status) n_rejected++;
    return o;
  endfunction

  // Offers one request; valid stays high into the next request when no gap is drawn
  task automatic issue_request(input req_t r, input bit given, input rsp_t want);
    int unsigned gap;
    rsp_t        predicted;
    gap = tx_no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk_i); while (!req_if.ready);
    predicted = predict_response(r);
    pending_rsp_q.push_back(given ? want : predicted);
    n_requests++;
  endtask

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input int unsigned data,
                          input int unsigned count);
    req_t r;
    r.cmd       = cmd;
    r.data_byte = BYTE_W'(data);
    r.count     = CNT_W'(count);
    issue_request(r, 1'b0, RSP_NONE);
  endtask

  // Drops valid and waits until every outstanding result has come back
  task automatic drain();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_rsp_q.size() != 0);
  endtask

  task automatic set_config(input logic [SYNC_LEN_W-1:0] len, input logic [PAT_W-1:0] pat);
    drain();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_SYNC_LEN;
    cfg_wdata_i <= PAT_W'(len);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_SYNC_PATTERN;
    cfg_wdata_i <= pat;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_len = len;
    shadow_pat = pat;
    n_settings++;
  endtask

  // Noise, the pattern (sometimes cut short or corrupted), a tail, then hunt and eat
  task automatic send_frame();
    int unsigned       plen;
    int unsigned       sent;
    int unsigned       k;
    int unsigned       avail;
    logic [BYTE_W-1:0] b;
    if (DEPTH - shadow_wr < 16) send_cmd(CMD_SHIFT, $urandom_range(0, 255), 0);
    repeat ($urandom_range(0, 5)) send_cmd(CMD_APPEND, $urandom_range(0, 255), 0);
    if (shadow_len == 0) plen = $urandom_range(1, PATTERN_MAX);
    else plen = (shadow_len > PATTERN_MAX) ? PATTERN_MAX : shadow_len;
    sent = ($urandom_range(0, 4) == 0) ? $urandom_range(1, plen) : plen;
    for (k = 0; k < sent; k++) begin
      b = pattern_byte(k);
      if ($urandom_range(0, 9) == 0) b ^= 8'h01 << $urandom_range(0, 7);
      send_cmd(CMD_APPEND, b, $urandom_range(0, 511));
    end
    if (sent == plen) repeat ($urandom_range(0, 3)) send_cmd(CMD_APPEND, $urandom_range(0, 255), 0);
    send_cmd(CMD_SYNC, $urandom_range(0, 255), $urandom_range(0, 511));
    avail = shadow_wr - shadow_rd;
    if ($urandom_range(0, 1) != 0) send_cmd(CMD_PEEK, 0, $urandom_range(0, avail));
    avail = shadow_wr - shadow_rd;
    send_cmd(CMD_CONSUME, 0, $urandom_range(0, (avail < plen) ? avail : plen));
  endtask

  task automatic run_mixed(input int unsigned quota);
    int unsigned start;
    int unsigned pick;
    int unsigned avail;
    int unsigned room;
    int unsigned cnt;
    start = n_requests;
    while (n_requests - start < quota) begin
      if ($urandom_range(0, 7) == 0) tx_no_idle = !tx_no_idle;
      avail = shadow_wr - shadow_rd;
      room  = DEPTH - shadow_wr;
      pick  = $urandom_range(0, 99);
      if (pick < 45) begin
        send_frame();
      end else if (pick < 58) begin
        case ($urandom_range(0, 4))
          0:       cnt = avail + 1;
          1:       cnt = $urandom_range(0, 511);
          default: cnt = $urandom_range(0, avail);
        endcase
        send_cmd(CMD_CONSUME, $urandom_range(0, 255), cnt);
      end else if (pick < 68) begin
        case ($urandom_range(0, 4))
          0:       cnt = avail;
          1:       cnt = $urandom_range(0, 511);
          default: cnt = (avail == 0) ? 0 : $urandom_range(0, avail - 1);
        endcase
        send_cmd(CMD_PEEK, $urandom_range(0, 255), cnt);
      end else if (pick < 76) begin
        send_cmd(CMD_SHIFT, $urandom_range(0, 255), $urandom_range(0, 511));
      end else if (pick < 82) begin
        send_cmd(CMD_SYNC, $urandom_range(0, 255), $urandom_range(0, 511));
      end else if (pick < 87) begin
        // Run the store into its end, one or two appends past it
        if (room <= 48)
          repeat (room + $urandom_range(1, 2))
            send_cmd(CMD_APPEND, $urandom_range(0, 255), $urandom_range(0, 511));
        else send_frame();
      end else if (pick < 90) begin
        drain();
      end else begin
        send_cmd(CMD_W'($urandom_range(0, 7)), $urandom_range(0, 255),
                 $urandom_range(0, 511));
      end
    end
  endtask

  // Output side stalls for a long stretch while requests keep coming
  task automatic hold_output();
    rsp_hold_cycles = HOLD_CYCLES;
    tx_no_idle      = 1'b1;
    repeat (20) begin
      send_cmd(CMD_APPEND, $urandom_range(0, 255), 0);
      send_cmd(CMD_PEEK, 0, 0);
    end
    tx_no_idle = 1'b0;
    drain();
  endtask

  // Empty the store, fill it to all 256 bytes and work on the full store
  task automatic fill_to_the_brim();
    send_cmd(CMD_SHIFT, 0, 0);
    send_cmd(CMD_CONSUME, 0, shadow_wr - shadow_rd);
    send_cmd(CMD_SHIFT, 0, 0);
    repeat (DEPTH + 1) send_cmd(CMD_APPEND, $urandom_range(0, 255), 0);
    send_cmd(CMD_PEEK, 0, DEPTH - 1);
    send_cmd(CMD_PEEK, 0, DEPTH);
    send_cmd(CMD_CONSUME, 0, DEPTH + 1);
    send_cmd(CMD_SHIFT, 0, 0);
    send_cmd(CMD_SYNC, 0, 0);
    send_cmd(CMD_CONSUME, 0, shadow_wr - shadow_rd);
    send_cmd(CMD_APPEND, 8'hA5, 0);
    send_cmd(CMD_SHIFT, 0, 0);
  endtask

  // Result side: random ready gaps, idle-free stretches, and the requested hold
  initial begin : rsp_sink
    int unsigned gap;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rsp_hold_cycles != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (rsp_hold_cycles) @(posedge clk_i);
        rsp_hold_cycles = 0;
        n_holds++;
      end
      if ($urandom_range(0, 39) == 0) rx_no_idle = !rx_no_idle;
      gap = rx_no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_if.valid && rsp_if.ready));
    end
  end

  // Compare every accepted result with the oldest expectation
  always @(posedge clk_i) begin : rsp_check
    rsp_t want;
    if (rst_ni === 1'b1 && rsp_if.valid && rsp_if.ready) begin
      if (pending_rsp_q.size() == 0) begin
        report_mismatch("result with nothing pending", 1, 0);
      end else begin
        want = pending_rsp_q.pop_front();
        n_checked++;
        if (rsp_if.data.status !== want.status)
          report_mismatch("status", rsp_if.data.status, want.status);
        if (rsp_if.data.found !== want.found)
          report_mismatch("found", rsp_if.data.found, want.found);
        if (rsp_if.data.discarded !== want.discarded)
          report_mismatch("discarded", rsp_if.data.discarded, want.discarded);
        if (rsp_if.data.peek_data !== want.peek_data)
          report_mismatch("peek_data", rsp_if.data.peek_data, want.peek_data);
        if (rsp_if.data.readable !== want.readable)
          report_mismatch("readable", rsp_if.data.readable, want.readable);
        if (rsp_if.data.writable !== want.writable)
          report_mismatch("writable", rsp_if.data.writable, want.writable);
      end
    end
  end

  // Ends the run when neither channel moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    wait (rst_ni === 1'b1);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("Watchdog: no request or result moved for %0d cycles", quiet);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned           k;
    int unsigned           ph;
    logic [SYNC_LEN_W-1:0] len;
    logic [PAT_W-1:0]      pat;
    step_row_t             row;
    req_t                  r;
    rst_ni       <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= CFG_SYNC_LEN;
    cfg_wdata_i  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    for (k = 0; k < N_ROWS; k++) begin
      row         = DIRECTED_ROWS[k];
      r.cmd       = row.cmd;
      r.data_byte = row.data_byte;
      r.count     = row.count;
      issue_request(r, row.given, row.want);
    end
    drain();

    // Random phases, each under its own register setting
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       begin len = 3'd1; pat = 32'h0000_00FF; end
        1:       begin len = 3'd4; pat = 32'hFFFF_FFFF; end
        2:       begin len = 3'd3; pat = $urandom; end
        3:       begin len = 3'd0; pat = 32'h0000_0000; end
        4:       begin len = 3'd7; pat = $urandom; end
        5:       begin len = 3'd2; pat = $urandom; end
        6:       begin len = 3'd4; pat = 32'h0000_0000; end
        default: begin len = 3'd5; pat = $urandom; end
      endcase
      set_config(len, pat);
      run_mixed(75);
      if (ph == 2) hold_output();
      if (ph == 4) fill_to_the_brim();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_rsp_q.size() != 0)
      report_mismatch("results never returned", 0, pending_rsp_q.size());

    $display("Summary: %0d requests under %0d register settings, %0d results checked",
             n_requests, n_settings + 1, n_checked);
    $display("Summary: %0d syncs hit the full pattern, %0d rejected, %0d long output holds",
             n_found, n_rejected, n_holds);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/sbb_pkg.sv
rtl/core/sbb_stream_if.sv
rtl/core/sbb_store.sv
rtl/core/sbb_hunter.sv
rtl/core/sbb_ctrl.sv
rtl/core/shiftable_byte_buffer_sync_hunter_unit.sv
verif/tb_shiftable_byte_buffer_sync_hunter_unit.sv
